// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the quadrature decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define QD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define QD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QD_ASSERT(lbl, prop, msg)
`define QD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/qdec_pkg.sv
// Shared types and constants of the quadrature decoder.
package qdec_pkg;

	localparam int DataW = 32;
	localparam int ProdW = 2 * DataW;
	localparam int InTdataW = 8;
	localparam int OutTdataW = 104;

	// Command codes of an input item
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_MEASURE = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	// Count modes
	localparam logic [1:0] MODE_X1 = 2'd0;
	localparam logic [1:0] MODE_X2 = 2'd1;
	localparam logic [1:0] MODE_X4 = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_COUNT_MODE = 2'd0;
	localparam logic [1:0] REG_SPEED_SCALE = 2'd1;
	localparam logic [1:0] REG_TICK_RATE = 2'd2;

	localparam logic [DataW-1:0] SPEED_SCALE_RST = 32'd65536;
	localparam logic [DataW-1:0] TICK_RATE_RST = 32'd1000000;

	// Controller to datapath
	typedef struct packed {
		logic accept;    // input transfer this cycle
		logic mul_en;    // register a product
		logic mul_sel;   // 0: acceleration operands, 1: speed operands
		logic div_start; // start a division of the product
		logic accel_wr;  // store quotient as acceleration
		logic speed_wr;  // store quotient as speed, shift history
		logic out_load;  // load the output register
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_valid;
	} ctl_sts_t;

endpackage

// File: hw/rtl/quadrature_decoder_with_speed.sv
// Top level of the quadrature decoder with speed and acceleration measurement.
// Each input transfer is one sample of encoder lines A and B with a command. A steady stream of
// sample and reset items goes through at one transfer per cycle while the output is taken. For a
// measure item the speed and the acceleration each need one 32x32 multiply and one 64-by-32
// division on a shared bit-serial divider (64 steps each); no input is taken until its result is
// in the output register. Every input transfer yields exactly one output transfer. Configuration
// writes take effect at once and are meant to be done while the block is idle.
module quadrature_decoder_with_speed (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [1:0] command, [2] a_level, [3] b_level, [7:4] zero
	input  logic [qdec_pkg::InTdataW-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] position_count, [63:32] speed, [95:64] acceleration,
	// [96] illegal_transition, [103:97] zero
	output logic [qdec_pkg::OutTdataW-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [qdec_pkg::DataW-1:0]          cfg_data
);

	qdec_pkg::ctl_cmd_t          cmd;
	qdec_pkg::ctl_sts_t          sts;
	logic [qdec_pkg::DataW-1:0]  position_count;
	logic [qdec_pkg::DataW-1:0]  speed;
	logic [qdec_pkg::DataW-1:0]  acceleration;
	logic                        illegal_transition;

	qdec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.command   (s_tdata[1:0]),
		.out_ready (m_tready),
		.sts       (sts),
		.in_ready  (s_tready),
		.cmd       (cmd)
	);

	qdec_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.command            (s_tdata[1:0]),
		.a_level            (s_tdata[2]),
		.b_level            (s_tdata[3]),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.out_ready          (m_tready),
		.position_count     (position_count),
		.speed              (speed),
		.acceleration       (acceleration),
		.illegal_transition (illegal_transition)
	);

	assign m_tvalid = sts.out_valid;
	assign m_tdata = {7'd0, illegal_transition, acceleration, speed, position_count};

endmodule

// File: hw/rtl/qdec_div.sv
// Bit-serial unsigned 64 by 32 divider, one quotient bit per cycle.
`include "assert_macros.svh"

module qdec_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [qdec_pkg::ProdW-1:0]     dividend,
	input  logic [qdec_pkg::DataW-1:0]     divisor,
	output logic                           done,
	output logic [qdec_pkg::ProdW-1:0]     quotient
);

	localparam int CntW = $clog2(qdec_pkg::ProdW);
	localparam logic [CntW-1:0] CntLast = CntW'(qdec_pkg::ProdW - 1);

	logic                         busy_q;
	logic                         done_q;
	logic [CntW-1:0]              cnt_q;
	logic [qdec_pkg::ProdW-1:0]   num_q;
	logic [qdec_pkg::DataW-1:0]   rem_q;
	logic [qdec_pkg::DataW-1:0]   den_q;
	logic [qdec_pkg::DataW:0]     rem_sh;
	logic [qdec_pkg::DataW:0]     rem_sub;
	logic                         fits;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, num_q[qdec_pkg::ProdW-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		fits = rem_sh >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntLast);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntLast)
					busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[qdec_pkg::ProdW-2:0], fits};
			rem_q <= fits ? rem_sub[qdec_pkg::DataW-1:0] : rem_sh[qdec_pkg::DataW-1:0];
		end
	end

	assign done = done_q;
	assign quotient = num_q;

	`QD_ASSERT(a_no_restart, start |-> !busy_q, "divider started while busy")
	`QD_ASSERT_ALWAYS(a_done_pulse, done_q |=> !done_q, "divider done longer than one cycle")

endmodule

// File: hw/rtl/qdec_dp.sv
// Datapath: edge counter, measurement state, shared multiplier and divider, output register.
`include "assert_macros.svh"

module qdec_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  qdec_pkg::ctl_cmd_t                cmd,
	output qdec_pkg::ctl_sts_t                sts,
	input  logic [1:0]                        command,
	input  logic                              a_level,
	input  logic                              b_level,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [qdec_pkg::DataW-1:0]        cfg_data,
	input  logic                              out_ready,
	output logic [qdec_pkg::DataW-1:0]        position_count,
	output logic [qdec_pkg::DataW-1:0]        speed,
	output logic [qdec_pkg::DataW-1:0]        acceleration,
	output logic                              illegal_transition
);

	localparam int W = qdec_pkg::DataW;
	localparam logic [W-1:0] One = W'(1);
	localparam logic [W-1:0] MinusOne = '1;
	localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

	// configuration
	logic [1:0]   mode_q;
	logic [W-1:0] scale_q;
	logic [W-1:0] rate_q;

	// measurement state
	logic [W-1:0] edge_q;
	logic [W-1:0] last_cnt_q;
	logic [W-1:0] ticks_q;
	logic [W-1:0] spd_q;
	logic [W-1:0] spd1_q;
	logic [W-1:0] spd2_q;
	logic [W-1:0] acc_q;
	logic         last_a_q;
	logic         last_b_q;
	logic         flag_q;

	// arithmetic
	logic [qdec_pkg::ProdW-1:0] prod_q;
	logic                       neg_q;
	logic [qdec_pkg::ProdW-1:0] quot;
	logic                       div_done;

	// output register
	logic         out_valid_q;
	logic [W-1:0] out_pos_q;
	logic [W-1:0] out_spd_q;
	logic [W-1:0] out_acc_q;
	logic         out_flag_q;

	logic         a_chg;
	logic         b_chg;
	logic         is_reset;
	logic [W-1:0] cnt_step;
	logic [W-1:0] edge_nx;
	logic [W-1:0] spd_nx;
	logic         flag_nx;
	logic [W:0]   acc_diff;
	logic         a_neg;
	logic [W-1:0] a_mag;
	logic [W-1:0] s_diff;
	logic         s_neg;
	logic [W-1:0] s_mag;
	logic [W-1:0] mul_a;
	logic [W-1:0] mul_b;
	logic         mul_neg;
	logic [W-1:0] elapsed;
	logic [W-1:0] quot_sat;

	// truncated quotient clamped to the signed range, sign applied
	function automatic logic [W-1:0] sat_quot(input logic neg,
			input logic [qdec_pkg::ProdW-1:0] q);
		logic [W-1:0] r;
		if (neg) begin
			r = (q > {{W{1'b0}}, MinNeg}) ? MinNeg : (W'(0) - q[W-1:0]);
		end else begin
			r = (q > {{W{1'b0}}, MaxPos}) ? MaxPos : q[W-1:0];
		end
		return r;
	endfunction

	// edge detection and count step
	always_comb begin
		a_chg = a_level != last_a_q;
		b_chg = b_level != last_b_q;
		is_reset = command == qdec_pkg::CMD_RESET;
		cnt_step = '0;
		if (a_chg && b_chg) begin
			cnt_step = '0;
		end else if (a_chg) begin
			if (a_level)
				cnt_step = b_level ? One : MinusOne;
			else if (mode_q != qdec_pkg::MODE_X1)
				cnt_step = b_level ? MinusOne : One;
		end else if (b_chg && mode_q != qdec_pkg::MODE_X1 && mode_q != qdec_pkg::MODE_X2) begin
			if (b_level)
				cnt_step = a_level ? MinusOne : One;
			else
				cnt_step = a_level ? One : MinusOne;
		end
		edge_nx = edge_q;
		spd_nx = spd_q;
		flag_nx = flag_q;
		if (cmd.accept) begin
			edge_nx = is_reset ? '0 : edge_q + cnt_step;
			spd_nx = is_reset ? '0 : spd_q;
			flag_nx = !is_reset && a_chg && b_chg;
		end
	end

	// multiplier operands: signed differences as sign and magnitude
	always_comb begin
		acc_diff = {spd1_q[W-1], spd1_q} - {spd2_q[W-1], spd2_q};
		a_neg = acc_diff[W];
		a_mag = a_neg ? W'(-acc_diff) : acc_diff[W-1:0];
		s_diff = edge_q - last_cnt_q;
		s_neg = s_diff[W-1];
		s_mag = s_neg ? (W'(0) - s_diff) : s_diff;
		mul_a = cmd.mul_sel ? s_mag : a_mag;
		mul_b = cmd.mul_sel ? scale_q : rate_q;
		mul_neg = cmd.mul_sel ? s_neg : a_neg;
		elapsed = (ticks_q == '0) ? One : ticks_q;
		quot_sat = sat_quot(neg_q, quot);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
			neg_q <= mul_neg;
		end
	end

	qdec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (elapsed),
		.done     (div_done),
		.quotient (quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= qdec_pkg::MODE_X4;
			scale_q <= qdec_pkg::SPEED_SCALE_RST;
			rate_q <= qdec_pkg::TICK_RATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qdec_pkg::REG_COUNT_MODE:  mode_q <= cfg_data[1:0];
				qdec_pkg::REG_SPEED_SCALE: scale_q <= cfg_data;
				qdec_pkg::REG_TICK_RATE:   rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// counter and measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= '0;
			last_cnt_q <= '0;
			ticks_q <= '0;
			spd_q <= '0;
			spd1_q <= '0;
			spd2_q <= '0;
			acc_q <= '0;
			last_a_q <= 1'b0;
			last_b_q <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			edge_q <= edge_nx;
			flag_q <= flag_nx;
			if (cmd.accept) begin
				if (is_reset) begin
					last_cnt_q <= '0;
					ticks_q <= '0;
					spd_q <= '0;
				end else begin
					last_a_q <= a_level;
					last_b_q <= b_level;
					if (ticks_q != '1)
						ticks_q <= ticks_q + One;
				end
			end
			if (cmd.accel_wr)
				acc_q <= quot_sat;
			if (cmd.speed_wr) begin
				spd2_q <= spd1_q;
				spd1_q <= spd_q;
				spd_q <= quot_sat;
				last_cnt_q <= edge_q;
				ticks_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pos_q <= edge_nx;
			out_spd_q <= spd_nx;
			out_acc_q <= acc_q;
			out_flag_q <= flag_nx;
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_valid = out_valid_q;
	assign position_count = out_pos_q;
	assign speed = out_spd_q;
	assign acceleration = out_acc_q;
	assign illegal_transition = out_flag_q;

	`QD_ASSERT(a_count_holds, !cmd.accept |=> $stable(edge_q), "count moved without a transfer")

endmodule

// File: hw/rtl/qdec_ctrl.sv
// Controller: input handshake and the sequence of a speed measurement.
`include "assert_macros.svh"

module qdec_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          command,
	input  logic                out_ready,
	input  qdec_pkg::ctl_sts_t  sts,
	output logic                in_ready,
	output qdec_pkg::ctl_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_A = 3'd1;
	localparam logic [2:0] ST_STA_A = 3'd2;
	localparam logic [2:0] ST_RUN_A = 3'd3;
	localparam logic [2:0] ST_MUL_S = 3'd4;
	localparam logic [2:0] ST_STA_S = 3'd5;
	localparam logic [2:0] ST_RUN_S = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_free;
	logic       accept;

	// next state and commands
	always_comb begin
		out_free = !sts.out_valid || out_ready;
		in_ready = (state_q == ST_IDLE) && out_free;
		accept = in_valid && in_ready;
		cmd = '0;
		cmd.accept = accept;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command == qdec_pkg::CMD_MEASURE)
						state_nx = ST_MUL_A;
					else
						cmd.out_load = 1'b1;
				end
			end
			ST_MUL_A: begin
				cmd.mul_en = 1'b1;
				state_nx = ST_STA_A;
			end
			ST_STA_A: begin
				cmd.div_start = 1'b1;
				state_nx = ST_RUN_A;
			end
			ST_RUN_A: begin
				if (sts.div_done) begin
					cmd.accel_wr = 1'b1;
					state_nx = ST_MUL_S;
				end
			end
			ST_MUL_S: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = 1'b1;
				state_nx = ST_STA_S;
			end
			ST_STA_S: begin
				cmd.div_start = 1'b1;
				state_nx = ST_RUN_S;
			end
			ST_RUN_S: begin
				if (sts.div_done) begin
					cmd.speed_wr = 1'b1;
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	`QD_ASSERT(a_measure_seq, (accept && command == qdec_pkg::CMD_MEASURE) |=> state_q == ST_MUL_A,
		"measure transfer did not start the multiply")
	`QD_ASSERT(a_load_free, cmd.out_load |-> out_free, "output loaded over an untaken result")

endmodule

// File: sim/qdec_checker.sv
// Checker for the quadrature decoder: predicts each result from the input transfers and compares.
module qdec_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// [1:0] command, [2] a_level, [3] b_level, [7:4] zero
	input  logic [qdec_pkg::InTdataW-1:0]  s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] position_count, [63:32] speed, [95:64] acceleration,
	// [96] illegal_transition, [103:97] zero
	input  logic [qdec_pkg::OutTdataW-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [qdec_pkg::DataW-1:0]     cfg_data,
	output int                             errors,
	output int                             outstanding
);

	typedef struct packed {
		logic [qdec_pkg::DataW-1:0] position;
		logic [qdec_pkg::DataW-1:0] speed;
		logic [qdec_pkg::DataW-1:0] accel;
		logic                       illegal;
	} tick_result_t;

	// Shadow copy of the registers and of the decoder state
	logic [1:0]                 mode;
	logic [qdec_pkg::DataW-1:0] scale;
	logic [qdec_pkg::DataW-1:0] rate;
	logic [qdec_pkg::DataW-1:0] count;
	logic [qdec_pkg::DataW-1:0] count_at_meas;
	logic [qdec_pkg::DataW-1:0] ticks;
	logic [qdec_pkg::DataW-1:0] speed_cur;
	logic [qdec_pkg::DataW-1:0] speed_prev;
	logic [qdec_pkg::DataW-1:0] speed_prev2;
	logic [qdec_pkg::DataW-1:0] accel_cur;
	logic                       last_a;
	logic                       last_b;

	tick_result_t pending_results[$];

	// Truncating divide of a sign and magnitude, clamped to the signed 32-bit range
	function automatic logic [qdec_pkg::DataW-1:0] clamp_quotient(input logic neg,
			input logic [qdec_pkg::ProdW-1:0] mag, input logic [qdec_pkg::DataW-1:0] den);
		logic [qdec_pkg::ProdW-1:0] q;
		q = mag / den;
		if (neg) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return -q[qdec_pkg::DataW-1:0];
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[qdec_pkg::DataW-1:0];
	endfunction

	// Speed from the count change, acceleration from the two older speeds
	function automatic void update_speed();
		logic [qdec_pkg::DataW-1:0]        elapsed;
		logic [qdec_pkg::DataW-1:0]        delta;
		logic signed [qdec_pkg::ProdW-1:0] diff;
		logic [qdec_pkg::ProdW-1:0]        amag;
		logic [qdec_pkg::ProdW-1:0]        smag;
		logic                              aneg;
		logic                              sneg;
		elapsed = (ticks == '0) ? 32'd1 : ticks;
		diff = $signed(speed_prev) - $signed(speed_prev2);
		aneg = diff < 0;
		amag = aneg ? -diff : diff;
		delta = count - count_at_meas;
		sneg = delta[qdec_pkg::DataW-1];
		smag = {32'd0, sneg ? -delta : delta};
		accel_cur = clamp_quotient(aneg, amag * rate, elapsed);
		speed_prev2 = speed_prev;
		speed_prev = speed_cur;
		speed_cur = clamp_quotient(sneg, smag * scale, elapsed);
		count_at_meas = count;
		ticks = '0;
	endfunction

	// One tick of the decoder
	function automatic tick_result_t decode_tick(input logic [1:0] cmd, input logic a,
			input logic b);
		tick_result_t r;
		logic         a_moved;
		logic         b_moved;
		r.illegal = 1'b0;
		if (cmd == qdec_pkg::CMD_RESET) begin
			count = '0;
			count_at_meas = '0;
			speed_cur = '0;
			ticks = '0;
		end else begin
			a_moved = a != last_a;
			b_moved = b != last_b;
			if (a_moved && b_moved) begin
				r.illegal = 1'b1;
			end else if (a_moved) begin
				if (a)
					count = b ? count + 1 : count - 1;
				else if (mode != qdec_pkg::MODE_X1)
					count = b ? count - 1 : count + 1;
			end else if (b_moved && mode != qdec_pkg::MODE_X1
					&& mode != qdec_pkg::MODE_X2) begin
				if (b)
					count = a ? count - 1 : count + 1;
				else
					count = a ? count + 1 : count - 1;
			end
			last_a = a;
			last_b = b;
			if (ticks != '1)
				ticks = ticks + 1;
			if (cmd == qdec_pkg::CMD_MEASURE)
				update_speed();
		end
		r.position = count;
		r.speed = speed_cur;
		r.accel = accel_cur;
		return r;
	endfunction

	function automatic int check_field(input string name,
			input logic [qdec_pkg::DataW-1:0] exp, input logic [qdec_pkg::DataW-1:0] act);
		if (exp !== act) begin
			$error("%s: expected %0d, actual %0d", name, $signed(exp), $signed(act));
			return 1;
		end
		return 0;
	endfunction

	// Track register writes, queue predictions, compare each output transfer
	always @(posedge clk or negedge arst_n) begin : watch
		tick_result_t want;
		int           bad;
		if (!arst_n) begin
			mode = qdec_pkg::MODE_X4;
			scale = qdec_pkg::SPEED_SCALE_RST;
			rate = qdec_pkg::TICK_RATE_RST;
			count = '0;
			count_at_meas = '0;
			ticks = '0;
			speed_cur = '0;
			speed_prev = '0;
			speed_prev2 = '0;
			accel_cur = '0;
			last_a = 1'b0;
			last_b = 1'b0;
			pending_results.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				unique case (cfg_index)
					qdec_pkg::REG_COUNT_MODE: mode = cfg_data[1:0];
					qdec_pkg::REG_SPEED_SCALE: scale = cfg_data;
					qdec_pkg::REG_TICK_RATE: rate = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(decode_tick(s_tdata[1:0], s_tdata[2], s_tdata[3]));
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("output transfer with no result expected: position_count %0d",
						$signed(m_tdata[31:0]));
					bad++;
				end else begin
					want = pending_results.pop_front();
					bad += check_field("position_count", want.position, m_tdata[31:0]);
					bad += check_field("speed", want.speed, m_tdata[63:32]);
					bad += check_field("acceleration", want.accel, m_tdata[95:64]);
					bad += check_field("illegal_transition", {31'd0, want.illegal},
						{31'd0, m_tdata[96]});
				end
			end
			errors <= errors + bad;
			outstanding <= pending_results.size();
		end
	end

endmodule

// File: sim/tb_quadrature_decoder_with_speed.sv
// Testbench top of the quadrature decoder: clock, reset, stimulus, stalls and verdict.
module tb_quadrature_decoder_with_speed;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_TICKS = 100;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [qdec_pkg::InTdataW-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [qdec_pkg::OutTdataW-1:0] m_tdata;
	logic                           cfg_we;
	logic [1:0]                     cfg_index;
	logic [qdec_pkg::DataW-1:0]     cfg_data;

	int   errors;
	int   outstanding;
	int   idle_cycles = 0;
	int   sink_hold = 0;
	bit   src_gaps;
	bit   sink_stalls;
	// Gray position of the encoder lines and the current direction of travel
	logic [1:0] enc;
	logic [1:0] turn;

	quadrature_decoder_with_speed i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	qdec_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output side: bursts of backpressure
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= (sink_hold == 1);
		end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			sink_hold <= $urandom_range(1, 13);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL quadrature_decoder_with_speed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// One tick transfer, after an optional gap; tvalid stays high on return
	task automatic send_tick(input logic [1:0] cmd, input logic a, input logic b);
		if (src_gaps && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, b, a, cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait until every result is back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [qdec_pkg::DataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic start_phase(input logic [1:0] mode, input logic [qdec_pkg::DataW-1:0] scale,
			input logic [qdec_pkg::DataW-1:0] rate);
		settle();
		write_reg(qdec_pkg::REG_COUNT_MODE, mode);
		write_reg(qdec_pkg::REG_SPEED_SCALE, scale);
		write_reg(qdec_pkg::REG_TICK_RATE, rate);
		// unmapped index, must leave the others alone
		write_reg(REG_SPARE, $urandom);
		cfg_we <= 1'b0;
	endtask

	// Mostly one-line gray steps with direction changes, some holds, jumps and glitches
	task automatic run_random(input int n);
		logic [1:0] cmd;
		int         pick;
		repeat (n) begin
			if ($urandom_range(0, 99) < 10)
				turn = 2'd0 - turn;
			pick = $urandom_range(0, 99);
			if (pick < 65)
				enc = enc + turn;
			else if (pick >= 90)
				enc = 2'($urandom);
			else if (pick >= 82)
				enc = enc + 2'd2;
			pick = $urandom_range(0, 99);
			if (pick < 8)
				cmd = qdec_pkg::CMD_MEASURE;
			else if (pick < 10)
				cmd = qdec_pkg::CMD_RESET;
			else if (pick < 13)
				cmd = CMD_SPARE;
			else
				cmd = qdec_pkg::CMD_SAMPLE;
			send_tick(cmd, enc[1], enc[1] ^ enc[0]);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= qdec_pkg::REG_COUNT_MODE;
		cfg_data <= '0;
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		enc = 2'd0;
		turn = 2'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset settings (x4)
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b0, 1'b0);
		send_tick(qdec_pkg::CMD_MEASURE, 1'b0, 1'b0);
		// one full cycle counting up
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b0, 1'b1);
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b1, 1'b1);
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b1, 1'b0);
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b0, 1'b0);
		send_tick(qdec_pkg::CMD_MEASURE, 1'b0, 1'b0);
		// one full cycle counting down
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b1, 1'b0);
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b1, 1'b1);
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b0, 1'b1);
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b0, 1'b0);
		send_tick(qdec_pkg::CMD_MEASURE, 1'b0, 1'b0);
		// both lines change at once, count holds
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b1, 1'b1);
		send_tick(qdec_pkg::CMD_MEASURE, 1'b0, 1'b0);
		// spare command samples like a plain tick
		send_tick(CMD_SPARE, 1'b1, 1'b0);
		// reset command takes no sample
		send_tick(qdec_pkg::CMD_RESET, 1'b0, 1'b1);
		send_tick(qdec_pkg::CMD_MEASURE, 1'b1, 1'b0);
		send_tick(qdec_pkg::CMD_SAMPLE, 1'b1, 1'b1);
		send_tick(qdec_pkg::CMD_MEASURE, 1'b1, 1'b1);
		run_random(PHASE_TICKS / 2);

		// x1, every factor at its maximum: speeds and accelerations saturate
		start_phase(qdec_pkg::MODE_X1, '1, '1);
		run_random(PHASE_TICKS);
		// x2, zero scale, slowest tick rate
		start_phase(qdec_pkg::MODE_X2, '0, 32'd1);
		run_random(PHASE_TICKS);
		// spare mode counts like x4; zero tick rate gives zero acceleration
		start_phase(MODE_SPARE, $urandom, '0);
		run_random(PHASE_TICKS);
		start_phase(qdec_pkg::MODE_X4, $urandom_range(1, 1 << 20), $urandom);
		run_random(PHASE_TICKS);

		// final stretch at full rate
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		start_phase(2'($urandom_range(0, 3)), $urandom, $urandom_range(1, 1000000));
		run_random(PHASE_TICKS);

		settle();
		repeat (150) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("PASS quadrature_decoder_with_speed");
		else
			$display("FAIL quadrature_decoder_with_speed");
		$finish;
	end

endmodule
